// ===== hdl/modat_pkg.sv =====
// Package for the minute-of-day action trigger: payload and control structs,
// operation and status codes, and the built-in default schedule tables.
// No dependencies.
package modat_pkg;

  localparam int unsigned FLAG_W     = 7;
  localparam int unsigned MINUTE_W   = 11;
  localparam int unsigned ENTRY_W    = 12;
  localparam int unsigned SEL_W      = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [MINUTE_W-1:0]       DAY_LAST_MINUTE = 11'd1439;
  localparam logic signed [ENTRY_W-1:0] UNUSED_ENTRY    = -12'sd1;

  localparam int unsigned INIT_ACTIONS   = 7;
  localparam int unsigned INIT_SCHEDULES = 3;
  localparam int unsigned INIT_VALS_N    = 37;

  localparam int unsigned INIT_LEN [INIT_ACTIONS][INIT_SCHEDULES] = '{
    '{1, 5, 48}, '{1, 12, 12}, '{1, 1, 24}, '{1, 12, 24},
    '{1, 1, 1},  '{1, 1, 12},  '{1, 12, 12}
  };

  localparam int unsigned INIT_USED [INIT_ACTIONS][INIT_SCHEDULES] = '{
    '{1, 5, 0}, '{1, 1, 4}, '{0, 1, 0}, '{0, 12, 0},
    '{0, 0, 0}, '{1, 1, 4}, '{1, 1, 4}
  };

  // start of each table's defaults within INIT_VALS
  localparam int unsigned INIT_OFF [INIT_ACTIONS][INIT_SCHEDULES] = '{
    '{0, 1, 6},    '{6, 7, 8},    '{12, 12, 13}, '{13, 13, 25},
    '{25, 25, 25}, '{25, 26, 27}, '{31, 32, 33}
  };

  localparam int unsigned INIT_VALS [INIT_VALS_N] = '{
    720, 300, 480, 660, 840, 1020,
    720, 720, 420, 600, 780, 960,
    660,
    0, 120, 240, 360, 480, 600, 720, 840, 960, 1080, 1200, 1320,
    720, 720, 420, 600, 780, 960,
    720, 720, 420, 600, 780, 960
  };

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_SKIP   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_SELECT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]                mode;
    logic [2:0]                action;
    logic [1:0]                schedule;
    logic [MINUTE_W-1:0]       minute;
    logic [5:0]                entry_index;
    logic signed [ENTRY_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] triggered_flags;
    logic [1:0]        status;
    logic              new_trigger;
  } out_item_t;

  typedef struct packed {
    logic init_step;
    logic load;
    logic exec;
    logic search;
    logic respond;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic go_search;
    logic search_end;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [ENTRY_W-1:0] init_entry(int unsigned a, int unsigned s,
                                                          int unsigned k);
    logic signed [ENTRY_W-1:0] v;
    v = UNUSED_ENTRY;
    if (a < INIT_ACTIONS && s < INIT_SCHEDULES) begin
      if (k < INIT_USED[a][s]) begin
        v = ENTRY_W'(INIT_VALS[INIT_OFF[a][s] + k]);
      end
    end
    return v;
  endfunction

  function automatic int unsigned init_len(int unsigned a, int unsigned s,
                                           int unsigned slot_entries);
    int unsigned n;
    n = 0;
    if (a < INIT_ACTIONS && s < INIT_SCHEDULES) begin
      n = (INIT_LEN[a][s] > slot_entries) ? slot_entries : INIT_LEN[a][s];
    end
    return n;
  endfunction

endpackage

// ===== hdl/minute_of_day_action_trigger_top.sv =====
// Flow: an accepted item is registered, executed, optionally searched, then its result is
// registered at the output once the output is free. A tick search walks up to L entries of
// the selected table, one RAM read and compare per cycle, and stops at a hit. A new item is
// accepted only after the previous result has been handed to the output register.
// Reset: a sweep writes all ACTIONS*SCHEDULES*SLOT_ENTRIES entries (1344) with the default
// tables; input is stalled meanwhile, config writes are taken. Uses modat_pkg.
module minute_of_day_action_trigger_top
  import modat_pkg::*;
#(
  parameter int unsigned ACTIONS      = 7,
  parameter int unsigned SCHEDULES    = 3,
  parameter int unsigned SLOT_ENTRIES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  modat_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  modat_dp #(
    .ACTIONS     (ACTIONS),
    .SCHEDULES   (SCHEDULES),
    .SLOT_ENTRIES(SLOT_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ===== hdl/modat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module modat_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1344
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/modat_dp.sv =====
// Datapath: item and config registers, flag and last-minute state, table
// sweep and search counters, schedule RAM, output register. Uses modat_pkg, modat_ram.
module modat_dp
  import modat_pkg::*;
#(
  parameter int unsigned ACTIONS      = 7,
  parameter int unsigned SCHEDULES    = 3,
  parameter int unsigned SLOT_ENTRIES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_item_t              in_data_i,
  output out_item_t             out_data_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o
);

  localparam int unsigned DEPTH = ACTIONS * SCHEDULES * SLOT_ENTRIES;
  localparam int unsigned MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned AW    = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
  localparam int unsigned SW    = (SCHEDULES > 1) ? $clog2(SCHEDULES) : 1;
  localparam int unsigned KW    = (SLOT_ENTRIES > 1) ? $clog2(SLOT_ENTRIES) : 1;
  localparam int unsigned LW    = $clog2(SLOT_ENTRIES + 1);

  in_item_t                  item_q;
  logic [FLAG_W-1:0]         enable_q;
  logic [SEL_W-1:0]          sel_q;
  logic [ACTIONS-1:0]        trig_q;
  logic [MINUTE_W-1:0]       last_min_q [ACTIONS];

  logic [AW-1:0]             ia_q;
  logic [SW-1:0]             is_q;
  logic [KW-1:0]             ik_q;
  logic [MAW-1:0]            iaddr_q;

  logic [LW-1:0]             k_q;
  logic [LW-1:0]             len_q;
  logic [MAW-1:0]            base_q;
  logic                      rd_pend_q;
  logic                      fresh_q;
  status_e                   status_q;
  out_item_t                 out_q;
  logic                      out_vld_q;

  logic [AW-1:0]             act_idx;
  logic                      act_ok;
  logic [1:0]                sel_bits;
  logic                      en_bit;
  logic [LW-1:0]             wr_len;
  logic [LW-1:0]             srch_len;
  logic [MAW-1:0]            wr_addr;
  logic [MAW-1:0]            srch_base;
  status_e                   dec_status;
  logic                      do_clear;
  logic                      do_write;
  logic                      do_record;
  logic                      go_search;

  logic                      issue;
  logic                      hit;
  logic [MAW-1:0]            rd_addr;
  logic [ENTRY_W-1:0]        rd_data;
  logic                      mem_we;
  logic [MAW-1:0]            mem_waddr;
  logic [ENTRY_W-1:0]        mem_wdata;
  logic [FLAG_W-1:0]         flags;

  // ---- decode of the held item ----
  assign act_idx  = AW'(item_q.action);
  assign act_ok   = 32'(item_q.action) < ACTIONS;
  assign sel_bits = 2'(sel_q >> {item_q.action, 1'b0});
  assign en_bit   = 1'(enable_q >> item_q.action);
  assign wr_len   = LW'(init_len(32'(item_q.action), 32'(item_q.schedule), SLOT_ENTRIES));
  assign srch_len = LW'(init_len(32'(item_q.action), 32'(sel_bits), SLOT_ENTRIES));
  assign wr_addr  = MAW'((32'(item_q.action) * SCHEDULES + 32'(item_q.schedule))
                         * SLOT_ENTRIES + 32'(item_q.entry_index));
  assign srch_base = MAW'((32'(item_q.action) * SCHEDULES + 32'(sel_bits)) * SLOT_ENTRIES);

  always_comb begin
    dec_status = ST_DONE;
    do_clear   = 1'b0;
    do_write   = 1'b0;
    do_record  = 1'b0;
    go_search  = 1'b0;
    if (!act_ok) begin
      dec_status = ST_REJECT;
    end else begin
      case (mode_e'(item_q.mode))
        MODE_CLEAR: begin
          do_clear = 1'b1;
        end
        MODE_WRITE: begin
          if (32'(item_q.schedule) >= SCHEDULES || item_q.entry_index >= wr_len) begin
            dec_status = ST_REJECT;
          end else begin
            do_write = 1'b1;
          end
        end
        MODE_TICK: begin
          if (item_q.minute > DAY_LAST_MINUTE || item_q.minute == last_min_q[act_idx]) begin
            dec_status = ST_SKIP;
          end else begin
            do_record = 1'b1;
            go_search = (32'(sel_bits) < SCHEDULES) && en_bit && !trig_q[act_idx]
                        && (srch_len != '0);
          end
        end
        default: begin
          dec_status = ST_REJECT;
        end
      endcase
    end
  end

  // ---- search ----
  assign issue   = cmd_i.search && (k_q < len_q);
  assign rd_addr = base_q + MAW'(k_q);
  assign hit     = rd_pend_q && !rd_data[ENTRY_W-1]
                   && (rd_data[MINUTE_W-1:0] == item_q.minute);

  // ---- RAM port muxing: reset sweep or table write ----
  assign mem_we    = cmd_i.init_step || (cmd_i.exec && do_write);
  assign mem_waddr = cmd_i.init_step ? iaddr_q : wr_addr;
  assign mem_wdata = cmd_i.init_step ? init_entry(32'(ia_q), 32'(is_q), 32'(ik_q))
                                     : item_q.entry_value;

  modat_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (issue),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= '0;
      sel_q     <= '0;
      trig_q    <= '0;
      for (int i = 0; i < ACTIONS; i++) begin
        last_min_q[i] <= '0;
      end
      ia_q      <= '0;
      is_q      <= '0;
      ik_q      <= '0;
      iaddr_q   <= '0;
      k_q       <= '0;
      rd_pend_q <= 1'b0;
      fresh_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ENABLE: enable_q <= cfg_data_i[FLAG_W-1:0];
          CFG_SELECT: sel_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (cmd_i.init_step) begin
        iaddr_q <= iaddr_q + 1'b1;
        if (ik_q == KW'(SLOT_ENTRIES - 1)) begin
          ik_q <= '0;
          if (is_q == SW'(SCHEDULES - 1)) begin
            is_q <= '0;
            ia_q <= ia_q + 1'b1;
          end else begin
            is_q <= is_q + 1'b1;
          end
        end else begin
          ik_q <= ik_q + 1'b1;
        end
      end

      if (cmd_i.exec) begin
        k_q       <= '0;
        rd_pend_q <= 1'b0;
        fresh_q   <= 1'b0;
        if (do_clear) begin
          trig_q[act_idx] <= 1'b0;
        end
        if (do_record) begin
          last_min_q[act_idx] <= item_q.minute;
        end
      end else if (cmd_i.search) begin
        k_q       <= k_q + LW'(issue);
        rd_pend_q <= issue;
        if (hit) begin
          trig_q[act_idx] <= 1'b1;
          fresh_q         <= 1'b1;
        end
      end

      if (cmd_i.respond) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      status_q <= dec_status;
      len_q    <= srch_len;
      base_q   <= srch_base;
    end
    if (cmd_i.respond) begin
      out_q.triggered_flags <= flags;
      out_q.status          <= status_q;
      out_q.new_trigger     <= fresh_q;
    end
  end

  for (genvar g = 0; g < FLAG_W; g++) begin : g_flag
    if (g < ACTIONS) begin : g_on
      assign flags[g] = trig_q[g];
    end else begin : g_off
      assign flags[g] = 1'b0;
    end
  end

  assign sts_o.init_last  = (iaddr_q == MAW'(DEPTH - 1));
  assign sts_o.go_search  = go_search;
  assign sts_o.search_end = hit || (k_q == len_q);
  assign sts_o.out_free   = !out_vld_q || !out_stall_i;

  assign out_data_o  = out_q;
  assign out_valid_o = out_vld_q;

`ifndef SYNTHESIS
  a_hit_marks_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.search && hit) |=> fresh_q)
    else $error("search hit did not mark new trigger");

  a_pend_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (k_q != '0))
    else $error("pending table read without an issued entry");

  a_fresh_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.new_trigger) |-> (out_q.status == ST_DONE))
    else $error("new trigger reported with non-done status");

  a_no_result_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.init_step |-> !out_vld_q)
    else $error("result present during table sweep");
`endif

endmodule

// ===== hdl/modat_ctrl.sv =====
// Controller state machine: reset sweep, item accept, execute, table search
// and result hand-off. Uses modat_pkg.
module modat_ctrl
  import modat_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.go_search ? S_SEARCH : S_RESP;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.search_end) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule
